@@ src/rtrg_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtrg_pkg
// Shared types and constants of the ring and tree route generator.
// -----------------------------------------------------------------------------
package rtrg_pkg;

  localparam int RANK_W = 6;   // rank field width
  localparam int NODE_W = 7;   // node count / fanout width
  localparam int KIND_W = 2;   // topology kind width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W = 7;    // widest register

  // topology kinds
  localparam logic [KIND_W-1:0] KIND_RING  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRAPH = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOPOLOGY_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TREE_FANOUT   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ERR,
    ST_SINGLE,
    ST_RING,
    ST_GRAPH_SRC,
    ST_GRAPH_DST,
    ST_TREE_CMP,
    ST_DIV_A,
    ST_DIV_B,
    ST_TREE_LCA,
    ST_POP_RD,
    ST_POP_EMIT
  } state_t;

  typedef enum logic [2:0] {
    SEL_ERR,
    SEL_SRC,
    SEL_DST,
    SEL_CUR,
    SEL_A,
    SEL_STACK
  } emit_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      latch_in;
    logic      ring_init;
    logic      ring_step;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
    logic      div_start;
    logic      div_sel_b;
    logic      div_load;
    logic      push;
    logic      pop_rd;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              out_free;
    logic              err;
    logic              equal;
    logic [KIND_W-1:0] kind;
    logic              ring_done;
    logic              a_eq_b;
    logic              a_gt_b;
    logic              div_done;
    logic              stack_empty;
  } sts_t;

endpackage

@@ src/rtrg_in_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtrg_in_if
// Request channel: source and destination rank.
// -----------------------------------------------------------------------------
interface rtrg_in_if;
  logic                       valid;
  logic                       ready;
  logic [rtrg_pkg::RANK_W-1:0] source_rank;
  logic [rtrg_pkg::RANK_W-1:0] dest_rank;

  modport source (output valid, output source_rank, output dest_rank, input ready);
  modport sink   (input valid, input source_rank, input dest_rank, output ready);
endinterface

@@ src/rtrg_out_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtrg_out_if
// Result channel: one hop rank per word.
// -----------------------------------------------------------------------------
interface rtrg_out_if;
  logic                       valid;
  logic                       ready;
  logic [rtrg_pkg::RANK_W-1:0] hop_rank;
  logic                       last_hop;
  logic                       route_status;

  modport source (output valid, output hop_rank, output last_hop, output route_status,
                  input ready);
  modport sink   (input valid, input hop_rank, input last_hop, input route_status,
                  output ready);
endinterface

@@ src/ring_tree_route_generator_top.sv @@
`timescale 1ns / 1ps
// Ring, graph, equal and error routes pass the setup state after accept, then load their first word.
// Tree routes climb in steps of one compare state, then the bit-serial parent divider,
// and each word of the descending part takes a stack read, then an emit.
// One request at a time: a new request is accepted only back in the idle state.
// Synchronous active-low reset; registers reset to ring, 64 nodes, fanout 2.
// -----------------------------------------------------------------------------
// ring_tree_route_generator_top
// Emits the ranks of a ring, k-ary tree or direct route, one word per hop.
// -----------------------------------------------------------------------------
module ring_tree_route_generator_top #(
  parameter int MAX_NODES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rtrg_in_if.sink                        in_ch,
  rtrg_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rtrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtrg_pkg::CFG_W-1:0]     cfg_wdata
);

  rtrg_pkg::cmd_t cmd;
  rtrg_pkg::sts_t sts;

  // sequencer
  rtrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  rtrg_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_src     (in_ch.source_rank),
    .in_dst     (in_ch.dest_rank),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_hop    (out_ch.hop_rank),
    .out_last   (out_ch.last_hop),
    .out_status (out_ch.route_status),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ src/rtrg_div.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtrg_div
// Restoring divider, one quotient bit per cycle, for the tree parent step.
// -----------------------------------------------------------------------------
module rtrg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rtrg_pkg::RANK_W-1:0] dividend,
  input  logic [rtrg_pkg::NODE_W-1:0] divisor,
  output logic [rtrg_pkg::RANK_W-1:0] quotient,
  output logic                        done
);

  localparam int CNT_W = $clog2(rtrg_pkg::RANK_W + 1);

  logic [rtrg_pkg::RANK_W-1:0] q_r, q_nxt;
  logic [rtrg_pkg::NODE_W-1:0] rem_r, rem_nxt;
  logic [rtrg_pkg::NODE_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [rtrg_pkg::NODE_W:0]   trial;
  logic                        fits;

  // one shift-subtract step
  always_comb begin
    trial = {rem_r, q_r[rtrg_pkg::RANK_W-1]};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      // zero fanout acts as one
      dvs_nxt  = (divisor == '0) ? rtrg_pkg::NODE_W'(1) : divisor;
      cnt_nxt  = CNT_W'(rtrg_pkg::RANK_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[rtrg_pkg::RANK_W-2:0], fits};
      rem_nxt = fits ? rtrg_pkg::NODE_W'(trial - {1'b0, dvs_r})
                     : trial[rtrg_pkg::NODE_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

@@ src/rtrg_dp.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtrg_dp
// Datapath: registers, ring walker, tree climb, down-path stack, output word.
// -----------------------------------------------------------------------------
module rtrg_dp #(
  parameter int MAX_NODES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rtrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtrg_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [rtrg_pkg::RANK_W-1:0]    in_src,
  input  logic [rtrg_pkg::RANK_W-1:0]    in_dst,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [rtrg_pkg::RANK_W-1:0]    out_hop,
  output logic                           out_last,
  output logic                           out_status,
  input  rtrg_pkg::cmd_t                 cmd,
  output rtrg_pkg::sts_t                 sts
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int FW = $clog2(MAX_NODES + 1);
  localparam int NW = rtrg_pkg::NODE_W;
  localparam int RW = rtrg_pkg::RANK_W;

  // configuration
  logic [rtrg_pkg::KIND_W-1:0] kind_r;
  logic [NW-1:0]               count_r, fanout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= rtrg_pkg::KIND_RING;
      count_r  <= NW'(64);
      fanout_r <= NW'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        rtrg_pkg::REG_TOPOLOGY_KIND: kind_r   <= cfg_wdata[rtrg_pkg::KIND_W-1:0];
        rtrg_pkg::REG_NODE_COUNT:    count_r  <= cfg_wdata[NW-1:0];
        rtrg_pkg::REG_TREE_FANOUT:   fanout_r <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // saturated node count
  logic [NW-1:0] n_eff;
  assign n_eff = (count_r > NW'(MAX_NODES)) ? NW'(MAX_NODES) : count_r;

  // request and walk registers
  logic [RW-1:0] src_r, dst_r, a_r, b_r, cur_r;
  logic [NW-1:0] rem_r;
  logic          fwd_r;
  logic [RW-1:0] quo;
  logic          div_done;

  // ring distances
  logic [NW-1:0] fwd_d, rev_d;
  always_comb begin
    if (src_r <= dst_r) fwd_d = NW'(dst_r) - NW'(src_r);
    else                fwd_d = NW'(dst_r) + n_eff - NW'(src_r);
    rev_d = n_eff - fwd_d;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      src_r <= in_src;
      dst_r <= in_dst;
      a_r   <= in_src;
      b_r   <= in_dst;
      cur_r <= in_src;
    end else begin
      if (cmd.ring_step) begin
        if (fwd_r) cur_r <= (NW'(cur_r) + 1'b1 == n_eff) ? '0 : cur_r + 1'b1;
        else       cur_r <= (cur_r == '0) ? RW'(n_eff - 1'b1) : cur_r - 1'b1;
      end
      if (cmd.div_load) begin
        if (cmd.div_sel_b) b_r <= quo;
        else               a_r <= quo;
      end
    end
    if (cmd.ring_init) begin
      fwd_r <= (fwd_d <= rev_d);
      rem_r <= (fwd_d <= rev_d) ? fwd_d : rev_d;
    end else if (cmd.ring_step) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  // parent step: (x - 1) / fanout
  logic [RW-1:0] div_x;
  assign div_x = cmd.div_sel_b ? b_r : a_r;

  rtrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_x - 1'b1),
    .divisor  (fanout_r),
    .quotient (quo),
    .done     (div_done)
  );

  // down-path stack
  logic [RW-1:0] stack_mem [MAX_NODES];
  logic [RW-1:0] stack_rd_r;
  logic [FW-1:0] fill_r, fill_nxt;

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push)        fill_nxt = fill_r + 1'b1;
    else if (cmd.pop_rd) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= '0;
    else        fill_r <= fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) stack_mem[fill_r[AW-1:0]] <= b_r;
    if (cmd.pop_rd) stack_rd_r <= stack_mem[fill_nxt[AW-1:0]];
  end

  // output word register
  logic          out_valid_r;
  logic [RW-1:0] hop_r;
  logic          last_r, status_r;
  logic [RW-1:0] hop_sel;

  always_comb begin
    case (cmd.emit_sel)
      rtrg_pkg::SEL_SRC:   hop_sel = src_r;
      rtrg_pkg::SEL_DST:   hop_sel = dst_r;
      rtrg_pkg::SEL_CUR:   hop_sel = cur_r;
      rtrg_pkg::SEL_A:     hop_sel = a_r;
      rtrg_pkg::SEL_STACK: hop_sel = stack_rd_r;
      default:             hop_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (cmd.emit)               out_valid_r <= 1'b1;
    else if (out_ready)              out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hop_r    <= hop_sel;
      status_r <= (cmd.emit_sel == rtrg_pkg::SEL_ERR);
      last_r   <= cmd.emit_last || (cmd.emit_sel == rtrg_pkg::SEL_ERR);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hop    = hop_r;
  assign out_last   = last_r;
  assign out_status = status_r;

  // status to controller
  always_comb begin
    sts.out_free    = !out_valid_r || out_ready;
    sts.err         = (NW'(src_r) >= n_eff) || (NW'(dst_r) >= n_eff);
    sts.equal       = (src_r == dst_r);
    sts.kind        = kind_r;
    sts.ring_done   = (rem_r == '0);
    sts.a_eq_b      = (a_r == b_r);
    sts.a_gt_b      = (a_r > b_r);
    sts.div_done    = div_done;
    sts.stack_empty = (fill_r == '0);
  end

  // checks
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("word loaded over an untaken word");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> fill_r != '0) else $error("pop from empty stack");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> fill_r < FW'(MAX_NODES)) else $error("push to full stack");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> last_r) else $error("error word not last");

endmodule

@@ src/rtrg_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rtrg_ctrl
// Controller: sequences one route request through the datapath.
// -----------------------------------------------------------------------------
module rtrg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtrg_pkg::sts_t sts,
  output rtrg_pkg::cmd_t cmd
);

  rtrg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rtrg_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtrg_pkg::ST_IDLE:
        if (in_valid) state_nxt = rtrg_pkg::ST_SETUP;
      rtrg_pkg::ST_SETUP: begin
        if (sts.err)                              state_nxt = rtrg_pkg::ST_ERR;
        else if (sts.equal)                       state_nxt = rtrg_pkg::ST_SINGLE;
        else if (sts.kind == rtrg_pkg::KIND_RING) state_nxt = rtrg_pkg::ST_RING;
        else if (sts.kind == rtrg_pkg::KIND_TREE) state_nxt = rtrg_pkg::ST_TREE_CMP;
        else                                      state_nxt = rtrg_pkg::ST_GRAPH_SRC;
      end
      rtrg_pkg::ST_ERR, rtrg_pkg::ST_SINGLE, rtrg_pkg::ST_GRAPH_DST:
        if (sts.out_free) state_nxt = rtrg_pkg::ST_IDLE;
      rtrg_pkg::ST_RING:
        if (sts.out_free && sts.ring_done) state_nxt = rtrg_pkg::ST_IDLE;
      rtrg_pkg::ST_GRAPH_SRC:
        if (sts.out_free) state_nxt = rtrg_pkg::ST_GRAPH_DST;
      rtrg_pkg::ST_TREE_CMP: begin
        if (sts.a_eq_b)                     state_nxt = rtrg_pkg::ST_TREE_LCA;
        else if (!sts.a_gt_b)               state_nxt = rtrg_pkg::ST_DIV_B;
        else if (sts.out_free)              state_nxt = rtrg_pkg::ST_DIV_A;
      end
      rtrg_pkg::ST_DIV_A, rtrg_pkg::ST_DIV_B:
        if (sts.div_done) state_nxt = rtrg_pkg::ST_TREE_CMP;
      rtrg_pkg::ST_TREE_LCA, rtrg_pkg::ST_POP_EMIT:
        if (sts.out_free)
          state_nxt = sts.stack_empty ? rtrg_pkg::ST_IDLE : rtrg_pkg::ST_POP_RD;
      rtrg_pkg::ST_POP_RD:
        state_nxt = rtrg_pkg::ST_POP_EMIT;
      default:
        state_nxt = rtrg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.emit_sel = rtrg_pkg::SEL_ERR;
    in_ready     = 1'b0;
    case (state_r)
      rtrg_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      rtrg_pkg::ST_SETUP:
        cmd.ring_init = 1'b1;
      rtrg_pkg::ST_ERR:
        cmd.emit = sts.out_free;
      rtrg_pkg::ST_SINGLE: begin
        cmd.emit      = sts.out_free;
        cmd.emit_sel  = rtrg_pkg::SEL_SRC;
        cmd.emit_last = 1'b1;
      end
      rtrg_pkg::ST_RING: begin
        cmd.emit      = sts.out_free;
        cmd.emit_sel  = rtrg_pkg::SEL_CUR;
        cmd.emit_last = sts.ring_done;
        cmd.ring_step = sts.out_free;
      end
      rtrg_pkg::ST_GRAPH_SRC: begin
        cmd.emit     = sts.out_free;
        cmd.emit_sel = rtrg_pkg::SEL_SRC;
      end
      rtrg_pkg::ST_GRAPH_DST: begin
        cmd.emit      = sts.out_free;
        cmd.emit_sel  = rtrg_pkg::SEL_DST;
        cmd.emit_last = 1'b1;
      end
      rtrg_pkg::ST_TREE_CMP: begin
        // larger side climbs: source side is emitted, destination side stacked
        cmd.emit_sel = rtrg_pkg::SEL_A;
        if (!sts.a_eq_b && sts.a_gt_b) begin
          cmd.emit      = sts.out_free;
          cmd.div_start = sts.out_free;
        end else if (!sts.a_eq_b) begin
          cmd.push      = 1'b1;
          cmd.div_sel_b = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      rtrg_pkg::ST_DIV_A:
        cmd.div_load = sts.div_done;
      rtrg_pkg::ST_DIV_B: begin
        cmd.div_sel_b = 1'b1;
        cmd.div_load  = sts.div_done;
      end
      rtrg_pkg::ST_TREE_LCA: begin
        cmd.emit      = sts.out_free;
        cmd.emit_sel  = rtrg_pkg::SEL_A;
        cmd.emit_last = sts.stack_empty;
      end
      rtrg_pkg::ST_POP_RD:
        cmd.pop_rd = 1'b1;
      rtrg_pkg::ST_POP_EMIT: begin
        cmd.emit      = sts.out_free;
        cmd.emit_sel  = rtrg_pkg::SEL_STACK;
        cmd.emit_last = sts.stack_empty;
      end
      default: ;
    endcase
  end

endmodule
